// ----- rtl/core/nsc_pkg.sv -----
// nsc_pkg: shared types, constants and a helper function of the sentence checker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

    localparam int MAX_LINE_DEF    = 255;
    localparam int COUNT_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int MIN_LEN         = 6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_START     = 3'd2;
    localparam logic [2:0] ERR_NO_STAR   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd5;
    localparam logic [2:0] ERR_MISMATCH  = 3'd6;

    typedef struct packed {
        logic [2:0] code;
        logic [7:0] xor_sum;
        logic [7:0] rx_sum;
        logic [7:0] length;
    } rec_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t n;
        n.ok    = 1'b1;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            n.value = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            n.value = 4'd9 + {1'b0, c[2:0]};
        end
        else
        begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nsc_front.sv -----
// nsc_front: accepts bytes, tracks the open line and classifies it at the line end.
// Depends on nsc_pkg; feeds one rec_t per finished line into the queue.
`timescale 1ns / 1ps
`default_nettype none

module nsc_front #(
    parameter int MAX_LINE = nsc_pkg::MAX_LINE_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          q_full,
    output logic               in_ready,
    output logic               rec_push,
    output nsc_pkg::rec_t      rec
);
    import nsc_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE + 1);

    logic             in_line_reg,  in_line_next;
    logic [POS_W-1:0] pos_reg,      pos_next;
    logic             start_ok_reg, start_ok_next;
    logic             star_reg,     star_next;
    logic [7:0]       xor_reg,      xor_next;
    logic [1:0]       digits_reg,   digits_next;
    logic [7:0]       hex_reg,      hex_next;
    logic             hex_ok_reg,   hex_ok_next;

    logic             accept;
    logic             term;
    nibble_t          nib;
    logic [POS_W+7:0] pos_ext;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;
    assign term     = (in_byte == CH_CR) || (in_byte == CH_LF);
    assign rec_push = accept && term && in_line_reg;
    assign nib      = hex_nibble(in_byte);
    assign pos_ext  = {8'd0, pos_reg};

    always_comb
    begin
        priority if (pos_reg < POS_W'(MIN_LEN))
            rec.code = ERR_SHORT;
        else if (!start_ok_reg)
            rec.code = ERR_START;
        else if (!star_reg)
            rec.code = ERR_NO_STAR;
        else if (digits_reg != 2'd2)
            rec.code = ERR_TRUNCATED;
        else if (!hex_ok_reg)
            rec.code = ERR_BAD_HEX;
        else if (hex_reg != xor_reg)
            rec.code = ERR_MISMATCH;
        else
            rec.code = ERR_OK;
        rec.xor_sum = xor_reg;
        rec.rx_sum  = (star_reg && digits_reg == 2'd2 && hex_ok_reg) ? hex_reg : 8'd0;
        rec.length  = pos_ext[7:0];
    end

    always_comb
    begin
        in_line_next  = in_line_reg;
        pos_next      = pos_reg;
        start_ok_next = start_ok_reg;
        star_next     = star_reg;
        xor_next      = xor_reg;
        digits_next   = digits_reg;
        hex_next      = hex_reg;
        hex_ok_next   = hex_ok_reg;
        if (accept)
        begin
            if (term)
            begin
                in_line_next  = 1'b0;
                pos_next      = '0;
                start_ok_next = 1'b0;
                star_next     = 1'b0;
                xor_next      = 8'd0;
                digits_next   = 2'd0;
                hex_next      = 8'd0;
                hex_ok_next   = 1'b1;
            end
            else
            begin
                if (!in_line_reg)
                begin
                    in_line_next  = 1'b1;
                    start_ok_next = (in_byte == CH_DOLLAR) || (in_byte == CH_BANG);
                    if (in_byte == CH_STAR)
                        star_next = 1'b1;
                end
                else if (!star_reg)
                begin
                    if (in_byte == CH_STAR)
                        star_next = 1'b1;
                    else
                        xor_next = xor_reg ^ in_byte;
                end
                else if (digits_reg != 2'd2)
                begin
                    if (nib.ok)
                        hex_next = {hex_reg[3:0], nib.value};
                    else
                        hex_ok_next = 1'b0;
                    digits_next = digits_reg + 2'd1;
                end
                if (pos_reg < POS_W'(MAX_LINE))
                    pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_line_reg  <= 1'b0;
            pos_reg      <= '0;
            start_ok_reg <= 1'b0;
            star_reg     <= 1'b0;
            xor_reg      <= 8'd0;
            digits_reg   <= 2'd0;
            hex_reg      <= 8'd0;
            hex_ok_reg   <= 1'b1;
        end
        else
        begin
            in_line_reg  <= in_line_next;
            pos_reg      <= pos_next;
            start_ok_reg <= start_ok_next;
            star_reg     <= star_next;
            xor_reg      <= xor_next;
            digits_reg   <= digits_next;
            hex_reg      <= hex_next;
            hex_ok_reg   <= hex_ok_next;
        end
    end

`ifndef SYNTH
    a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_LINE))
        else $error("line length past limit");
    a_digits_need_star: assert property (@(posedge clk) disable iff (!rst_n)
        (digits_reg != 2'd0) |-> star_reg)
        else $error("checksum digits counted without star");
    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |=> !in_line_reg && pos_reg == '0 && xor_reg == 8'd0)
        else $error("line state not cleared after line end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nsc_queue.sv -----
// nsc_queue: short queue of classified line records between front and back.
// Depends on nsc_pkg for rec_t.
`timescale 1ns / 1ps
`default_nettype none

module nsc_queue #(
    parameter int DEPTH = nsc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  nsc_pkg::rec_t      wr_data,
    output logic               full,
    input  wire logic          rd_en,
    output nsc_pkg::rec_t      rd_data,
    output logic               empty
);
    import nsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");
    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("record pushed into full queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a write");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nsc_back.sv -----
// nsc_back: takes classified line records, keeps the valid/rejected counters
// and holds the result register. Depends on nsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsc_back #(
    parameter int COUNT_BITS = nsc_pkg::COUNT_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  nsc_pkg::rec_t      rec,
    input  wire logic          q_empty,
    output logic               q_pop,
    input  wire logic          pop,
    output logic               empty,
    output logic               line_valid,
    output logic [2:0]         error_code,
    output logic [7:0]         computed_checksum,
    output logic [7:0]         received_checksum,
    output logic [7:0]         line_length,
    output logic [31:0]        valid_count,
    output logic [31:0]        rejected_count
);
    import nsc_pkg::*;

    logic                  out_valid_reg, out_valid_next;
    logic [COUNT_BITS-1:0] good_reg, good_next;
    logic [COUNT_BITS-1:0] bad_reg,  bad_next;
    logic                  ok;
    logic [COUNT_BITS+31:0] good_ext, bad_ext;

    logic        valid_reg;
    logic [2:0]  code_reg;
    logic [7:0]  xor_reg;
    logic [7:0]  rx_reg;
    logic [7:0]  len_reg;
    logic [31:0] vcnt_reg;
    logic [31:0] rcnt_reg;

    assign q_pop    = !q_empty && (!out_valid_reg || pop);
    assign ok       = (rec.code == ERR_OK);
    assign good_next = ok ? good_reg + 1'b1 : good_reg;
    assign bad_next  = ok ? bad_reg : bad_reg + 1'b1;
    assign good_ext = {32'd0, good_next};
    assign bad_ext  = {32'd0, bad_next};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            good_reg      <= '0;
            bad_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                good_reg <= good_next;
                bad_reg  <= bad_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            valid_reg <= ok;
            code_reg  <= rec.code;
            xor_reg   <= rec.xor_sum;
            rx_reg    <= rec.rx_sum;
            len_reg   <= rec.length;
            vcnt_reg  <= good_ext[31:0];
            rcnt_reg  <= bad_ext[31:0];
        end
    end

    assign empty             = !out_valid_reg;
    assign line_valid        = valid_reg;
    assign error_code        = code_reg;
    assign computed_checksum = xor_reg;
    assign received_checksum = rx_reg;
    assign line_length       = len_reg;
    assign valid_count       = vcnt_reg;
    assign rejected_count    = rcnt_reg;

`ifndef SYNTH
    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> ((good_reg != $past(good_reg)) != (bad_reg != $past(bad_reg))))
        else $error("exactly one counter must advance per line");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg && $stable(vcnt_reg)
            && $stable(code_reg))
        else $error("waiting result changed before pop");
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (line_valid == (error_code == ERR_OK)))
        else $error("verdict disagrees with error code");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/nmea_sentence_checker.sv -----
// Sentence checker top: one byte per cycle in while full is low; a result reaches the ports after the
// line-end item is accepted (record queued at that edge, result register loaded once it is free).
// Throughput: one item per cycle on both sides while results are popped; full rises only when the
// QUEUE_DEPTH-entry record queue fills while results are not popped.
// Reset (rst_n, async low) clears line state, queue pointers, counters and result valid.
`timescale 1ns / 1ps
`default_nettype none

module nmea_sentence_checker #(
    parameter int MAX_LINE    = nsc_pkg::MAX_LINE_DEF,
    parameter int COUNT_BITS  = nsc_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = nsc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        pop,
    output logic             empty,
    output logic             line_valid,
    output logic [2:0]       error_code,
    output logic [7:0]       computed_checksum,
    output logic [7:0]       received_checksum,
    output logic [7:0]       line_length,
    output logic [31:0]      valid_count,
    output logic [31:0]      rejected_count
);
    import nsc_pkg::*;

    logic in_ready;
    logic rec_push;
    rec_t rec_in;
    rec_t rec_out;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign full = !in_ready;

    nsc_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (push),
        .in_byte  (data_byte),
        .q_full   (q_full),
        .in_ready (in_ready),
        .rec_push (rec_push),
        .rec      (rec_in)
    );

    nsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (rec_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (rec_out),
        .empty   (q_empty)
    );

    nsc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .rec               (rec_out),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .pop               (pop),
        .empty             (empty),
        .line_valid        (line_valid),
        .error_code        (error_code),
        .computed_checksum (computed_checksum),
        .received_checksum (received_checksum),
        .line_length       (line_length),
        .valid_count       (valid_count),
        .rejected_count    (rejected_count)
    );

endmodule

`default_nettype wire

// ----- tb/nmea_sentence_checker_tb.sv -----
// Self-checking testbench for nmea_sentence_checker: byte stream in, one line verdict out.
// A built-in line-state predictor checks every verdict; depends on nsc_pkg and the RTL only.
`timescale 1ns / 1ps

module nmea_sentence_checker_tb;

    import nsc_pkg::*;

    localparam int LINE_CAP    = MAX_LINE_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic [7:0] bytes_t[$];

    typedef struct {
        logic        ok;
        logic [2:0]  code;
        logic [7:0]  xor_sum;
        logic [7:0]  rx_sum;
        logic [7:0]  length;
        logic [31:0] good;
        logic [31:0] bad;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        full;
    logic        empty;
    logic        line_valid;
    logic [2:0]  error_code;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [7:0]  line_length;
    logic [31:0] valid_count;
    logic [31:0] rejected_count;

    verdict_t verdict_q[$];
    bytes_t   no_tail;

    // predicted line state
    bit          ln_open = 1'b0;
    int          ln_len = 0;
    bit          ln_start_ok = 1'b0;
    bit          ln_star = 1'b0;
    logic [7:0]  ln_xor = 8'h00;
    int          ln_digits = 0;
    logic [7:0]  ln_hex = 8'h00;
    bit          ln_hex_ok = 1'b1;
    logic [31:0] good_cnt = '0;
    logic [31:0] bad_cnt = '0;

    int  errors = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_valid = 0;
    int  cycle_count = 0;
    int  hold_request = 0;
    int  hold_left = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;

    always #5 clk = ~clk;

    nmea_sentence_checker dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .data_byte         (data_byte),
        .pop               (pop),
        .empty             (empty),
        .line_valid        (line_valid),
        .error_code        (error_code),
        .computed_checksum (computed_checksum),
        .received_checksum (received_checksum),
        .line_length       (line_length),
        .valid_count       (valid_count),
        .rejected_count    (rejected_count)
    );

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c) - int'("0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c) - int'("a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c) - int'("A") + 10;
        end
        return -1;
    endfunction

    task automatic track_byte(input logic [7:0] c);
        verdict_t v;
        int       nib;
        if (c == CH_CR || c == CH_LF)
        begin
            if (ln_open)
            begin
                if (ln_len < MIN_LEN)
                    v.code = ERR_SHORT;
                else if (!ln_start_ok)
                    v.code = ERR_START;
                else if (!ln_star)
                    v.code = ERR_NO_STAR;
                else if (ln_digits < 2)
                    v.code = ERR_TRUNCATED;
                else if (!ln_hex_ok)
                    v.code = ERR_BAD_HEX;
                else if (ln_hex != ln_xor)
                    v.code = ERR_MISMATCH;
                else
                    v.code = ERR_OK;
                v.ok = (v.code == ERR_OK);
                if (v.ok)
                    good_cnt = good_cnt + 1;
                else
                    bad_cnt = bad_cnt + 1;
                v.xor_sum = ln_xor;
                v.rx_sum  = (ln_star && ln_digits >= 2 && ln_hex_ok) ? ln_hex : 8'h00;
                v.length  = ln_len[7:0];
                v.good    = good_cnt;
                v.bad     = bad_cnt;
                verdict_q.push_back(v);
                ln_open     = 1'b0;
                ln_len      = 0;
                ln_start_ok = 1'b0;
                ln_star     = 1'b0;
                ln_xor      = 8'h00;
                ln_digits   = 0;
                ln_hex      = 8'h00;
                ln_hex_ok   = 1'b1;
            end
        end
        else
        begin
            if (!ln_open)
            begin
                ln_open     = 1'b1;
                ln_start_ok = (c == CH_DOLLAR || c == CH_BANG);
                if (c == CH_STAR)
                    ln_star = 1'b1;
            end
            else if (!ln_star)
            begin
                if (c == CH_STAR)
                    ln_star = 1'b1;
                else
                    ln_xor ^= c;
            end
            else if (ln_digits < 2)
            begin
                nib = nibble_of(c);
                if (nib < 0)
                    ln_hex_ok = 1'b0;
                else
                    ln_hex = {ln_hex[3:0], nib[3:0]};
                ln_digits++;
            end
            if (ln_len < LINE_CAP)
                ln_len++;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            track_byte(data_byte);
    end

    always @(posedge clk)
    begin : verdict_checker
        verdict_t v;
        if (rst_n && pop && !empty)
        begin
            n_results++;
            if (line_valid === 1'b1)
                n_valid++;
            if (verdict_q.size() == 0)
            begin
                $error("unexpected verdict: code %0d, length %0d", error_code, line_length);
                errors++;
            end
            else
            begin
                v = verdict_q.pop_front();
                check_field("line_valid", 32'(v.ok), 32'(line_valid));
                check_field("error_code", 32'(v.code), 32'(error_code));
                check_field("computed_checksum", 32'(v.xor_sum), 32'(computed_checksum));
                check_field("received_checksum", 32'(v.rx_sum), 32'(received_checksum));
                check_field("line_length", 32'(v.length), 32'(line_length));
                check_field("valid_count", v.good, valid_count);
                check_field("rejected_count", v.bad, rejected_count);
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= !rx_idle_on || ($urandom_range(0, 99) >= 31);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d verdicts pending", cycle_count,
                 verdict_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    function automatic bytes_t str2q(input string s);
        bytes_t q;
        foreach (s[i])
            q.push_back(s[i]);
        return q;
    endfunction

    function automatic logic [7:0] content_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == CH_CR || b == CH_LF)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic bytes_t random_body(input int lo, input int hi);
        bytes_t     q;
        logic [7:0] b;
        repeat ($urandom_range(lo, hi))
        begin
            if ($urandom_range(0, 9) == 0)
                b = content_byte();
            else
                b = 8'($urandom_range(32, 126));
            if (b == CH_STAR)
                b = "#";
            q.push_back(b);
        end
        return q;
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (tx_idle_on)
        begin
            while ($urandom_range(0, 99) < 31)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
        end
        push      <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        n_items++;
    endtask

    task automatic send_bytes(input bytes_t q);
        foreach (q[i])
            send_byte(q[i]);
    endtask

    task automatic end_line();
        case ($urandom_range(0, 2))
            0: send_byte(CH_LF);
            1: send_byte(CH_CR);
            default:
            begin
                send_byte(CH_CR);
                send_byte(CH_LF);
            end
        endcase
    endtask

    task automatic send_raw_line(input string s);
        send_bytes(str2q(s));
        end_line();
    endtask

    task automatic send_sentence(input logic [7:0] lead, input bytes_t body, input bit lower,
                                 input logic [7:0] flip, input bytes_t tail);
        logic [7:0] sum;
        sum = flip;
        foreach (body[i])
            sum ^= body[i];
        send_byte(lead);
        send_bytes(body);
        send_byte(CH_STAR);
        send_bytes(str2q(lower ? $sformatf("%02x", sum) : $sformatf("%02X", sum)));
        send_bytes(tail);
        end_line();
    endtask

    task automatic test_valid_sentences();
        send_sentence(CH_DOLLAR, str2q("GPGGA,123519,4807.038,N"), 1'b0, 8'h00, no_tail);
        send_sentence(CH_BANG, str2q("AIVDM,1,1,,B"), 1'b1, 8'h00, no_tail);
        send_sentence(CH_DOLLAR, str2q("AB"), 1'b0, 8'h00, no_tail);
        send_sentence(CH_BANG, str2q("zz~"), 1'b1, 8'h00, no_tail);
    endtask

    task automatic test_reject_codes();
        string near_miss;
        near_miss = "/:@G`g +-";
        send_raw_line("$A*41");
        send_raw_line("$");
        send_raw_line("XGPGSA*00");
        send_raw_line("$GPRMC,1");
        send_raw_line("$GPRMC*4");
        send_raw_line("$GPRMC*");
        send_raw_line("$GPRMC*G");
        foreach (near_miss[i])
        begin
            send_bytes(str2q("$GP*"));
            send_byte(near_miss[i]);
            send_byte("0");
            end_line();
        end
        send_raw_line("$GPRMC*0Z");
        send_sentence(CH_DOLLAR, str2q("GPRMC,A"), 1'b0, 8'h01, no_tail);
        send_sentence(CH_BANG, str2q("GPRMC,A"), 1'b1, 8'h80, no_tail);
    endtask

    task automatic test_edge_bytes();
        bytes_t odd;
        odd = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_raw_line("*GPGGA*00");
        send_sentence(CH_DOLLAR, str2q("GPGLL"), 1'b0, 8'h00, str2q("*ZZ,junk"));
        send_sentence(CH_BANG, odd, 1'b0, 8'h00, no_tail);
        send_bytes(odd);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(CH_CR);
    endtask

    task automatic test_long_lines();
        send_sentence(CH_DOLLAR, random_body(256, 256), 1'b0, 8'h00, no_tail);
    endtask

    task automatic test_backpressure();
        hold_request = 300;
        repeat (8)
            send_raw_line("abc");
    endtask

    task automatic random_frame();
        bytes_t     body;
        logic [7:0] lead;
        int         pick;
        pick = $urandom_range(0, 99);
        body = random_body(0, 12);
        lead = $urandom_range(0, 1) ? CH_DOLLAR : CH_BANG;
        if (pick < 65)
        begin
            send_sentence(lead, body, 1'($urandom_range(0, 1)),
                          ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00,
                          ($urandom_range(0, 9) == 0) ? random_body(1, 4) : no_tail);
        end
        else if (pick < 85)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    send_byte(lead);
                    send_bytes(body);
                end
                1:
                begin
                    send_byte(lead);
                    send_bytes(body);
                    send_byte(CH_STAR);
                    send_byte(hex_char());
                end
                2:
                begin
                    send_byte(lead);
                    send_bytes(body);
                    send_byte(CH_STAR);
                    if ($urandom_range(0, 1))
                    begin
                        send_byte(content_byte());
                        send_byte(hex_char());
                    end
                    else
                    begin
                        send_byte(hex_char());
                        send_byte(content_byte());
                    end
                end
                default:
                    send_sentence(content_byte(), body, 1'b0, 8'h00, no_tail);
            endcase
            end_line();
        end
        else
        begin
            repeat ($urandom_range(1, 16))
            begin
                if ($urandom_range(0, 4) == 0)
                    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            end_line();
        end
    endtask

    task automatic test_random_traffic(input int budget, input int min_lines);
        int first_item;
        int first_result;
        first_item   = n_items;
        first_result = n_results;
        while (n_items - first_item < budget || n_results - first_result < min_lines)
            random_frame();
    endtask

    task automatic test_no_idle_stretch();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_long_lines();
        test_random_traffic(30, 3);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_sentences();
        test_reject_codes();
        test_edge_bytes();
        test_backpressure();
        test_random_traffic(40, 4);
        test_no_idle_stretch();
        push <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes; checked %0d line verdicts (%0d valid, %0d rejected).",
                 n_items, n_results, n_valid, n_results - n_valid);
        $display("Covered every error code, long-line saturation and a full-queue stall.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
